/* rtl/core/bgnc_pkg.sv */
package bgnc_pkg;

    // Grid limits.
    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 1024;

    // Shift line holds two full rows plus two cells of history.
    localparam int HIST_LEN   = 2 * MAX_COLUMNS + 2;
    localparam int HIST_IDX_W = $clog2(HIST_LEN);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int SUM_W = 4;

    // Configuration port.
    localparam int ROWS_CFG_W = 11;
    localparam int COLS_CFG_W = 6;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam int RESET_ROWS = 32;
    localparam int RESET_COLS = 32;

    // Job queue between the front and back parts; depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One bit per result kind, in raster order of the cells they belong to.
    typedef logic [3:0] t_kinds;
    localparam t_kinds KIND_UP_LEFT = 4'b0001;
    localparam t_kinds KIND_UP      = 4'b0010;
    localparam t_kinds KIND_LEFT    = 4'b0100;
    localparam t_kinds KIND_HERE    = 4'b1000;

    typedef struct packed {
        logic [SUM_W-1:0] sum_up_left;
        logic [SUM_W-1:0] sum_up;
        logic [SUM_W-1:0] sum_left;
        logic [SUM_W-1:0] sum_here;
        t_kinds           kinds;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_job;

    typedef struct packed {
        logic [SUM_W-1:0] neighbor_sum;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             frame_end;
    } t_result;

endpackage

/* rtl/core/bgnc_front.sv */
module bgnc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [bgnc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bgnc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_item_vld,
    input  logic                           i_cell,
    output logic                           o_job_vld,
    output bgnc_pkg::t_job                 o_job
);
    import bgnc_pkg::*;

    logic [ROW_W-1:0]      r_last_row;
    logic [COL_W:0]        r_cols;
    logic [COL_W-1:0]      r_last_col;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;
    logic [HIST_LEN-1:0]   r_hist;

    logic [ROWS_CFG_W-1:0] rows_req;
    logic [ROWS_CFG_W-1:0] rows_eff;
    logic [COLS_CFG_W-1:0] cols_req;
    logic [COLS_CFG_W-1:0] cols_eff;
    logic                  cfg_hit;

    logic [HIST_IDX_W-1:0] w_ext;
    logic [HIST_IDX_W-1:0] idx1 [3];
    logic [HIST_IDX_W-1:0] idx2 [3];
    logic [2:0]            col_ok;
    logic                  row_ok1;
    logic                  row_ok2;
    logic [2:0]            g0;
    logic [2:0]            g1;
    logic [2:0]            g2;
    logic [SUM_W-1:0]      s_here;
    logic [SUM_W-1:0]      s_up;
    logic [SUM_W-1:0]      s_left;
    logic [SUM_W-1:0]      s_up_left;
    logic                  last_row;
    logic                  last_col;
    t_kinds                kinds;

    // Zero acts as one, oversize clamps to the limit.
    always_comb begin
        rows_req = i_cfg_data[ROWS_CFG_W-1:0];
        cols_req = i_cfg_data[COLS_CFG_W-1:0];
        if (rows_req == '0) begin
            rows_eff = ROWS_CFG_W'(1);
        end else if (rows_req > ROWS_CFG_W'(MAX_ROWS)) begin
            rows_eff = ROWS_CFG_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_req;
        end
        if (cols_req == '0) begin
            cols_eff = COLS_CFG_W'(1);
        end else if (cols_req > COLS_CFG_W'(MAX_COLUMNS)) begin
            cols_eff = COLS_CFG_W'(MAX_COLUMNS);
        end else begin
            cols_eff = cols_req;
        end
        cfg_hit = i_cfg_valid && (i_cfg_index == CFG_ROWS || i_cfg_index == CFG_COLS);
    end

    // Gather the 3x3 block whose bottom right corner is the incoming cell.
    // Bit j of each row is the cell j columns to the left.
    always_comb begin
        w_ext = HIST_IDX_W'(r_cols);
        for (int j = 0; j < 3; j++) begin
            idx1[j] = w_ext + HIST_IDX_W'(j) - HIST_IDX_W'(1);
            idx2[j] = (w_ext << 1) + HIST_IDX_W'(j) - HIST_IDX_W'(1);
        end
        col_ok  = {r_col > COL_W'(1), r_col != '0, 1'b1};
        row_ok1 = (r_row != '0);
        row_ok2 = (r_row > ROW_W'(1));
        g0 = {r_hist[1], r_hist[0], i_cell} & col_ok;
        for (int j = 0; j < 3; j++) begin
            g1[j] = r_hist[idx1[j]] & col_ok[j] & row_ok1;
            g2[j] = r_hist[idx2[j]] & col_ok[j] & row_ok2;
        end
        s_here    = SUM_W'(g0[0]) + SUM_W'(g0[1]) + SUM_W'(g1[0]) + SUM_W'(g1[1]);
        s_up      = s_here + SUM_W'(g2[0]) + SUM_W'(g2[1]);
        s_left    = s_here + SUM_W'(g0[2]) + SUM_W'(g1[2]);
        s_up_left = s_up + SUM_W'(g0[2]) + SUM_W'(g1[2]) + SUM_W'(g2[2]);
    end

    always_comb begin
        last_row = (r_row == r_last_row);
        last_col = (r_col == r_last_col);
        kinds = '0;
        if (row_ok1 && col_ok[1]) begin
            kinds = kinds | KIND_UP_LEFT;
        end
        if (row_ok1 && last_col) begin
            kinds = kinds | KIND_UP;
        end
        if (last_row && col_ok[1]) begin
            kinds = kinds | KIND_LEFT;
        end
        if (last_row && last_col) begin
            kinds = kinds | KIND_HERE;
        end
        o_job_vld         = i_item_vld && (kinds != '0);
        o_job.sum_up_left = s_up_left;
        o_job.sum_up      = s_up;
        o_job.sum_left    = s_left;
        o_job.sum_here    = s_here;
        o_job.kinds       = kinds;
        o_job.row         = r_row;
        o_job.col         = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row <= ROW_W'(RESET_ROWS - 1);
            r_cols     <= (COL_W + 1)'(RESET_COLS);
            r_last_col <= COL_W'(RESET_COLS - 1);
            r_row      <= '0;
            r_col      <= '0;
            r_hist     <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_index == CFG_ROWS) begin
                r_last_row <= ROW_W'(rows_eff - ROWS_CFG_W'(1));
            end else begin
                r_cols     <= (COL_W + 1)'(cols_eff);
                r_last_col <= COL_W'(cols_eff - COLS_CFG_W'(1));
            end
            r_row  <= '0;
            r_col  <= '0;
            r_hist <= '0;
        end else if (i_item_vld) begin
            if (last_row && last_col) begin
                r_row  <= '0;
                r_col  <= '0;
                r_hist <= '0;
            end else begin
                r_hist <= {r_hist[HIST_LEN-2:0], i_cell};
                if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

endmodule

/* rtl/core/bgnc_queue.sv */
module bgnc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  bgnc_pkg::t_job i_wr_data,
    output logic           o_full,
    output logic           o_rd_vld,
    output bgnc_pkg::t_job o_rd_data,
    input  logic           i_rd_en
);
    import bgnc_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full    = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_rd_vld  = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_wr_en && !i_rd_en) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (!i_wr_en && i_rd_en) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* rtl/core/bgnc_back.sv */
module bgnc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_vld,
    input  bgnc_pkg::t_job    i_job,
    output logic              o_job_pop,
    output logic              o_result_vld,
    output bgnc_pkg::t_result o_result,
    input  logic              i_result_pop
);
    import bgnc_pkg::*;

    t_kinds  r_done;
    logic    r_out_vld;
    t_result r_out;

    t_kinds  remaining;
    t_kinds  pick;
    t_kinds  rest;
    logic    load;
    t_result n_out;

    // Hand out the pending results of the head job lowest kind first.
    always_comb begin
        remaining = i_job.kinds & ~r_done;
        pick      = remaining & (~remaining + t_kinds'(1));
        rest      = remaining & ~pick;
        load      = i_job_vld && (!r_out_vld || i_result_pop);
        o_job_pop = load && (rest == '0);

        case (pick)
            KIND_UP_LEFT: begin
                n_out = '{i_job.sum_up_left, i_job.row - ROW_W'(1),
                          i_job.col - COL_W'(1), 1'b0};
            end
            KIND_UP: begin
                n_out = '{i_job.sum_up, i_job.row - ROW_W'(1), i_job.col, 1'b0};
            end
            KIND_LEFT: begin
                n_out = '{i_job.sum_left, i_job.row, i_job.col - COL_W'(1), 1'b0};
            end
            KIND_HERE: begin
                n_out = '{i_job.sum_here, i_job.row, i_job.col, 1'b1};
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    assign o_result_vld = r_out_vld;
    assign o_result     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= '0;
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
            r_done    <= (rest == '0) ? t_kinds'(0) : (r_done | pick);
        end else if (i_result_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

/* rtl/core/binary_grid_neighbor_count.sv */
// With the job queue empty and the result register free, the edge accepting a beat writes
// its job into the queue, from which the first result goes on to the result register.
// Throughput: one cell per cycle while each cell gives at most one result and every result
// is popped as it comes; a cell in the last row or column can give up to four results, and
// the result port sets the pace then. A four-entry job queue absorbs the bursts.
// Reset (synchronous, active low) clears the position counters, the history, the job
// queue and the result valid flag, and sets the grid size to 32 rows by 32 columns.
module binary_grid_neighbor_count (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bgnc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bgnc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Cell stream, queue style.
    input  logic                             push,
    output logic                             full,
    input  logic                             i_cell_set,
    // Result stream, queue style.
    output logic                             empty,
    input  logic                             pop,
    output logic [bgnc_pkg::SUM_W-1:0]       o_neighbor_sum,
    output logic [bgnc_pkg::ROW_W-1:0]       o_out_row,
    output logic [bgnc_pkg::COL_W-1:0]       o_out_col,
    output logic                             o_frame_end
);
    import bgnc_pkg::*;

    // The front part tracks the raster position, keeps two rows plus two cells of
    // history in a shift line, and on every accepted beat computes all the window
    // sums that this cell completes. The sums travel as one job through a short
    // queue to the back part, which turns each job into one to four result beats.

    logic    item_vld;
    logic    job_wr;
    t_job    job_in;
    logic    job_rd_vld;
    t_job    job_head;
    logic    job_pop;
    logic    result_vld;
    t_result result;

    // Registers can always be written; the block is expected to be idle then.
    assign o_cfg_ready = 1'b1;

    // The queue is full only when no job slot is left, so a beat is taken while the
    // result register still waits to be popped.
    assign item_vld = push && !full;

    bgnc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item_vld  (item_vld),
        .i_cell      (i_cell_set),
        .o_job_vld   (job_wr),
        .o_job       (job_in)
    );

    bgnc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (job_wr),
        .i_wr_data (job_in),
        .o_full    (full),
        .o_rd_vld  (job_rd_vld),
        .o_rd_data (job_head),
        .i_rd_en   (job_pop)
    );

    bgnc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_vld    (job_rd_vld),
        .i_job        (job_head),
        .o_job_pop    (job_pop),
        .o_result_vld (result_vld),
        .o_result     (result),
        .i_result_pop (pop)
    );

    // Results come straight from the back part's output register.
    assign empty          = !result_vld;
    assign o_neighbor_sum = result.neighbor_sum;
    assign o_out_row      = result.out_row;
    assign o_out_col      = result.out_col;
    assign o_frame_end    = result.frame_end;

endmodule

/* rtl/core/bgnc_checker.sv */
module bgnc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             full,
    input logic                             empty,
    input logic                             pop,
    input logic [bgnc_pkg::SUM_W-1:0]       o_neighbor_sum,
    input logic [bgnc_pkg::ROW_W-1:0]       o_out_row,
    input logic [bgnc_pkg::COL_W-1:0]       o_out_col,
    input logic                             o_frame_end
);
    import bgnc_pkg::*;

    // Reset leaves no result waiting and room for input.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("block not empty after reset");

    // A waiting result beat stays put until popped.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_neighbor_sum) && $stable(o_out_row)
            && $stable(o_out_col) && $stable(o_frame_end))
        else $error("waiting result changed before pop");

    // A 3x3 window holds at most nine cells.
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_neighbor_sum <= SUM_W'(9))
        else $error("neighbor sum above nine");

    // The final cell is a corner, so its window has at most four cells in the grid.
    a_corner_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_frame_end |-> o_neighbor_sum <= SUM_W'(4))
        else $error("frame end sum above four");

endmodule

bind binary_grid_neighbor_count bgnc_checker u_checker (.*);

/* dv/bgnc_sum_checker.sv */
module bgnc_sum_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [bgnc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bgnc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_push,
    input  logic                            i_full,
    input  logic                            i_cell_set,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  logic [bgnc_pkg::SUM_W-1:0]      i_neighbor_sum,
    input  logic [bgnc_pkg::ROW_W-1:0]      i_out_row,
    input  logic [bgnc_pkg::COL_W-1:0]      i_out_col,
    input  logic                            i_frame_end,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_cells,
    output int                              o_sums,
    output int                              o_frame_ends,
    output int                              o_stall_cycles
);
    import bgnc_pkg::*;

    localparam int SHOWN_MAX = 20;

    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    // Bit 0 holds the cell taken in one beat ago, bit 1 the one before, and so on.
    logic [HIST_LEN-1:0]   history;
    int                    row_at;
    int                    col_at;
    t_result               expected_sums[$];
    int                    fails;
    int                    cells;
    int                    sums;
    int                    frame_ends;
    int                    stall_cycles;

    initial begin
        rows_reg     = ROWS_CFG_W'(RESET_ROWS);
        cols_reg     = COLS_CFG_W'(RESET_COLS);
        history      = '0;
        row_at       = 0;
        col_at       = 0;
        fails        = 0;
        cells        = 0;
        sums         = 0;
        frame_ends   = 0;
        stall_cycles = 0;
    end

    function automatic int rows_in_use();
        if (rows_reg == 0) return 1;
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic int cols_in_use();
        if (cols_reg == 0) return 1;
        return (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
    endfunction

    function automatic int past_cell(int back, logic cur);
        if (back == 0) return int'(cur);
        if (back < 0 || back > HIST_LEN) return 0;
        return int'(history[back - 1]);
    endfunction

    // Sum over the 3x3 window around (qr, qc), seen from the cell (r, c) just taken in.
    function automatic int window_total(int qr, int qc, int r, int c, int nr, int nc,
                                        logic cur);
        int total;
        int rr;
        int cc;
        total = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = qr + dr;
                cc = qc + dc;
                if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
                    total += past_cell((r - rr) * nc + (c - cc), cur);
                end
            end
        end
        return total;
    endfunction

    task automatic restart_frame();
        history = '0;
        row_at  = 0;
        col_at  = 0;
    endtask

    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= SHOWN_MAX) $display("bgnc_sum_checker: %s", msg);
    endtask

    task automatic queue_sum(input int qr, input int qc, input int r, input int c,
                             input int nr, input int nc, input logic cur, input logic last);
        t_result e;
        e.neighbor_sum = SUM_W'(window_total(qr, qc, r, c, nr, nc, cur));
        e.out_row      = ROW_W'(qr);
        e.out_col      = COL_W'(qc);
        e.frame_end    = last;
        expected_sums.push_back(e);
    endtask

    // One cell beat completes up to four cells, queued in raster order.
    task automatic predict_cell(input logic cur);
        int   nr;
        int   nc;
        logic last_row;
        logic last_col;
        nr       = rows_in_use();
        nc       = cols_in_use();
        last_row = (row_at == nr - 1);
        last_col = (col_at == nc - 1);
        if (row_at >= 1 && col_at >= 1)
            queue_sum(row_at - 1, col_at - 1, row_at, col_at, nr, nc, cur, 1'b0);
        if (row_at >= 1 && last_col)
            queue_sum(row_at - 1, col_at, row_at, col_at, nr, nc, cur, 1'b0);
        if (last_row && col_at >= 1)
            queue_sum(row_at, col_at - 1, row_at, col_at, nr, nc, cur, 1'b0);
        if (last_row && last_col) begin
            queue_sum(row_at, col_at, row_at, col_at, nr, nc, cur, 1'b1);
            restart_frame();
        end else begin
            history = {history[HIST_LEN-2:0], cur};
            if (last_col) begin
                col_at = 0;
                row_at++;
            end else begin
                col_at++;
            end
        end
    endtask

    task automatic check_sum();
        t_result e;
        if (expected_sums.size() == 0) begin
            report_mismatch($sformatf("sum %0d for cell (%0d,%0d) came with none expected",
                                      i_neighbor_sum, i_out_row, i_out_col));
            return;
        end
        e = expected_sums.pop_front();
        sums++;
        if (e.frame_end) frame_ends++;
        if (i_neighbor_sum !== e.neighbor_sum)
            report_mismatch($sformatf("cell (%0d,%0d): sum %0d, expected %0d",
                                      e.out_row, e.out_col, i_neighbor_sum, e.neighbor_sum));
        if (i_out_row !== e.out_row)
            report_mismatch($sformatf("row %0d, expected %0d", i_out_row, e.out_row));
        if (i_out_col !== e.out_col)
            report_mismatch($sformatf("column %0d, expected %0d", i_out_col, e.out_col));
        if (i_frame_end !== e.frame_end)
            report_mismatch($sformatf("cell (%0d,%0d): frame end %0b, expected %0b",
                                      e.out_row, e.out_col, i_frame_end, e.frame_end));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg = ROWS_CFG_W'(RESET_ROWS);
            cols_reg = COLS_CFG_W'(RESET_COLS);
            restart_frame();
            expected_sums.delete();
        end else begin
            // Writes to indexes past the register list leave everything alone.
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ROWS) begin
                    rows_reg = i_cfg_data[ROWS_CFG_W-1:0];
                    restart_frame();
                end else if (i_cfg_index == CFG_COLS) begin
                    cols_reg = i_cfg_data[COLS_CFG_W-1:0];
                    restart_frame();
                end
            end
            if (i_pop && !i_empty) check_sum();
            if (i_push && !i_full) begin
                cells++;
                predict_cell(i_cell_set);
            end
            if (i_push && i_full) stall_cycles++;
        end
        o_fail_count   <= fails;
        o_pending      <= expected_sums.size();
        o_cells        <= cells;
        o_sums         <= sums;
        o_frame_ends   <= frame_ends;
        o_stall_cycles <= stall_cycles;
    end

endmodule

/* dv/tb_top.sv */
module tb_top;
    import bgnc_pkg::*;

    // Register indexes past the end of the list; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Cells in the random part; the directed part before it sends about 160 more.
    localparam int RANDOM_CELLS = 324;
    // Long receiver hold-off, long enough for the job queue to fill and push to stall.
    localparam int HOLD_CYCLES  = 300;
    // Quiet cycles after the last expected sum.
    localparam int QUIET_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int RUN_LIMIT    = 3000000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_ROWS;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  push        = 1'b0;
    logic                  full;
    logic                  i_cell_set  = 1'b0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [SUM_W-1:0]      o_neighbor_sum;
    logic [ROW_W-1:0]      o_out_row;
    logic [COL_W-1:0]      o_out_col;
    logic                  o_frame_end;

    int fail_count;
    int pending;
    int cells_seen;
    int sums_seen;
    int frame_ends;
    int stall_cycles;
    int settings = 0;

    // When calm is set, neither side idles: back-to-back beats on both channels.
    bit calm     = 1'b0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    binary_grid_neighbor_count dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_cell_set     (i_cell_set),
        .empty          (empty),
        .pop            (pop),
        .o_neighbor_sum (o_neighbor_sum),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_frame_end    (o_frame_end)
    );

    bgnc_sum_checker u_sums (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_full         (full),
        .i_cell_set     (i_cell_set),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_neighbor_sum (o_neighbor_sum),
        .i_out_row      (o_out_row),
        .i_out_col      (o_out_col),
        .i_frame_end    (o_frame_end),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_cells        (cells_seen),
        .o_sums         (sums_seen),
        .o_frame_ends   (frame_ends),
        .o_stall_cycles (stall_cycles)
    );

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Size the block actually uses for a register value: zero acts as one,
    // anything past the limit acts as the limit.
    function automatic int size_in_use(int value, int limit);
        if (value == 0) return 1;
        return (value > limit) ? limit : value;
    endfunction

    // Offers one cell and returns at the edge that accepts it. Push is left high so
    // that a following cell can go out in the very next beat.
    task automatic send_cell(input logic value);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_cell_set <= value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // A stream of cells, each marked with the given percentage chance.
    task automatic run_cells(input int count, input int density);
        for (int k = 0; k < count; k++) send_cell($urandom_range(0, 99) < density);
        push <= 1'b0;
    endtask

    // Waits until every expected sum has come out and then a few quiet cycles more.
    // The pending count is registered, so a single zero is not trusted.
    task automatic settle();
        int quiet;
        int waited;
        quiet  = 0;
        waited = 0;
        while (quiet < QUIET_CYCLES && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
            quiet = (pending == 0) ? quiet + 1 : 0;
        end
    endtask

    // One register beat. Valid stays high; the caller lowers it after the last write.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // New grid size, written only once the block has gone idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] rows_data,
                             input logic [CFG_DATA_W-1:0] cols_data);
        settle();
        cfg_write(CFG_ROWS, rows_data);
        cfg_write(CFG_COLS, cols_data);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // Receiver: pops with random idle gaps and serves the one long hold-off on request.
    initial begin : result_sink
        int gap;
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = idle_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int                    random_cells;
        int                    roll;
        int                    nr;
        int                    nc;
        int                    frame_cells;
        int                    count;
        int                    density;
        bit                    leftover;
        logic [CFG_DATA_W-1:0] rows_data;
        logic [CFG_DATA_W-1:0] cols_data;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size is 32 by 32: the second row starts completing cells of the first.
        run_cells(40, 50);

        // Writes past the register list must neither change the size nor restart the
        // frame, so the same frame simply continues afterwards.
        settle();
        cfg_write(CFG_SPARE_LO, 11'h7FF);
        cfg_write(CFG_SPARE_HI, 11'h000);
        i_cfg_valid <= 1'b0;
        run_cells(10, 50);

        // Zero in both registers acts as a one-cell grid: every cell ends a frame.
        configure(11'h000, 11'h000);
        send_cell(1'b1);
        send_cell(1'b0);
        send_cell(1'b1);
        push <= 1'b0;

        // A full 3x3 frame: corners see 4, edges 6, the middle the top value of 9.
        configure(11'd3, 11'd3);
        run_cells(9, 100);

        // One row of two; the upper bits of the column data must be dropped.
        configure(11'd1, 11'h7C2);
        send_cell(1'b1);
        send_cell(1'b1);
        push <= 1'b0;

        // One column of two.
        configure(11'd2, 11'd1);
        send_cell(1'b1);
        send_cell(1'b0);
        push <= 1'b0;

        // All ones in both registers: rows and columns clamp to their limits. The
        // receiver holds off for a long stretch while cells keep coming, so the block
        // fills up and holds off the cell stream.
        configure(11'h7FF, 11'h7FF);
        calm     = 1'b1;
        hold_req = 1'b1;
        run_cells(90, 70);
        calm     = 1'b0;

        // Random part: mostly small grids sent as whole frames, now and then a clamped
        // or zero size, and partial frames cut short by the next register write.
        random_cells = 0;
        while (random_cells < RANDOM_CELLS) begin
            roll = $urandom_range(0, 99);
            if (roll < 5)       rows_data = '0;
            else if (roll < 10) rows_data = CFG_DATA_W'($urandom_range(1025, 2047));
            else if (roll < 15) rows_data = CFG_DATA_W'($urandom_range(7, 1024));
            else                rows_data = CFG_DATA_W'($urandom_range(1, 6));

            cols_data = CFG_DATA_W'($urandom);
            roll      = $urandom_range(0, 99);
            if (roll < 5)       cols_data[COLS_CFG_W-1:0] = '0;
            else if (roll < 10) cols_data[COLS_CFG_W-1:0] = COLS_CFG_W'($urandom_range(33, 63));
            else if (roll < 25) cols_data[COLS_CFG_W-1:0] = COLS_CFG_W'(MAX_COLUMNS);
            else                cols_data[COLS_CFG_W-1:0] = COLS_CFG_W'($urandom_range(1, 31));

            configure(rows_data, cols_data);
            nr          = size_in_use(int'(rows_data), MAX_ROWS);
            nc          = size_in_use(int'(cols_data[COLS_CFG_W-1:0]), MAX_COLUMNS);
            frame_cells = nr * nc;

            if (frame_cells <= 150 && $urandom_range(0, 4) != 0) begin
                // Whole frames, sometimes with the start of one more left hanging.
                count = frame_cells * $urandom_range(1, 2);
                if ($urandom_range(0, 2) == 0) count += $urandom_range(0, frame_cells - 1);
            end else begin
                count = $urandom_range(1, (frame_cells < 80) ? frame_cells : 80);
            end
            // The last stretch stops at the cell budget, even mid-frame.
            if (count > RANDOM_CELLS - random_cells) count = RANDOM_CELLS - random_cells;

            roll = $urandom_range(0, 9);
            if (roll == 0)      density = 0;
            else if (roll == 1) density = 100;
            else if (roll == 2) density = 15;
            else if (roll == 3) density = 85;
            else                density = 50;

            calm = ($urandom_range(0, 3) == 0);
            run_cells(count, density);
            random_cells += count;
        end
        calm = 1'b0;

        settle();
        leftover = (pending != 0);
        if (leftover) $display("tb_top: %0d expected sums never came out", pending);

        $display("tb_top: %0d cells in, %0d window sums checked, %0d frame ends, %0d grid sizes",
                 cells_seen, sums_seen, frame_ends, settings);
        $display("tb_top: the cell stream was held off by a full block on %0d cycles",
                 stall_cycles);
        if (fail_count == 0 && !leftover) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Guard against a hang anywhere above.
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bgnc_pkg.sv
rtl/core/bgnc_front.sv
rtl/core/bgnc_queue.sv
rtl/core/bgnc_back.sv
rtl/core/binary_grid_neighbor_count.sv
rtl/core/bgnc_checker.sv
dv/bgnc_sum_checker.sv
dv/tb_top.sv
